FILE: sv/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

FILE: sv/cbrs_pkg.sv
package cbrs_pkg;

   localparam int OFFSET_W      = 48;
   localparam int REQ_BYTES_W   = 26;
   localparam int CHUNK_W       = 41;
   localparam int INDEX_W       = 32;
   localparam int IN_CHUNK_W    = 40;
   localparam int REQ_DATA_W    = 80;
   localparam int RSP_DATA_W    = 128;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 4;
   localparam int DIV_STEPS     = OFFSET_W;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
   localparam int MAX_SEGMENTS_DEFAULT = 64;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(4194304);

   // register index decoded from paddr
   localparam logic REG_CHUNK_BYTES = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SPLIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic seg_emit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic seg_final;
      logic out_free;
   } status_type;

endpackage

FILE: sv/cbrs_ctrl.sv
module cbrs_ctrl
   import cbrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (status.out_free) begin
               cmd.seg_emit = 1'b1;
               if (status.seg_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/cbrs_dp.sv
module cbrs_dp
   import cbrs_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   cfg_we,
   input  logic [CHUNK_W-1:0]     cfg_wdata,
   output logic [CHUNK_W-1:0]     cfg_rdata,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam int SEG_CNT_W = $clog2(MAX_SEGMENTS);

   logic [CHUNK_W-1:0]     chunk_bytes_ff, chunk_bytes_in;
   logic [CHUNK_W-1:0]     csize_ff, csize_in;
   logic [OFFSET_W-1:0]    dividend_ff, dividend_in;
   logic [INDEX_W-1:0]     quo_ff, quo_in;
   logic [CHUNK_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [REQ_BYTES_W-1:0] left_ff, left_in;
   logic [REQ_BYTES_W-1:0] bufoff_ff, bufoff_in;
   logic [SEG_CNT_W-1:0]   seg_cnt_ff, seg_cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]  out_data_ff, out_data_in;
   logic                   out_last_ff, out_last_in;

   logic [CHUNK_W:0]       trial;
   logic [CHUNK_W:0]       shifted;
   logic [CHUNK_W-1:0]     room;
   logic [REQ_BYTES_W-1:0] take;
   logic [REQ_BYTES_W-1:0] left_after;
   logic                   seg_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bytes_ff <= CHUNK_RESET;
         out_valid_ff   <= 1'b0;
      end else begin
         chunk_bytes_ff <= chunk_bytes_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      csize_ff    <= csize_in;
      dividend_ff <= dividend_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      left_ff     <= left_in;
      bufoff_ff   <= bufoff_in;
      seg_cnt_ff  <= seg_cnt_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   // one restoring divide step per cycle
   assign shifted = {rem_ff, dividend_ff[OFFSET_W-1]};
   assign trial   = shifted - {1'b0, csize_ff};

   // segment arithmetic
   assign room       = csize_ff - rem_ff;
   assign take       = ({{(CHUNK_W-REQ_BYTES_W){1'b0}}, left_ff} < room)
                       ? left_ff : room[REQ_BYTES_W-1:0];
   assign left_after = left_ff - take;
   assign seg_final  = (left_after == '0)
                       || (seg_cnt_ff == SEG_CNT_W'(MAX_SEGMENTS - 1));

   always_comb begin
      chunk_bytes_in = cfg_we ? cfg_wdata : chunk_bytes_ff;
      csize_in       = csize_ff;
      dividend_in    = dividend_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      left_in        = left_ff;
      bufoff_in      = bufoff_ff;
      seg_cnt_in     = seg_cnt_ff;
      out_data_in    = out_data_ff;
      out_last_in    = out_last_ff;
      out_valid_in   = rsp_tready ? 1'b0 : out_valid_ff;

      if (cmd.load) begin
         csize_in    = (chunk_bytes_ff == '0) ? CHUNK_W'(1) : chunk_bytes_ff;
         dividend_in = req_tdata[OFFSET_W-1:0];
         left_in     = req_tdata[OFFSET_W +: REQ_BYTES_W];
         quo_in      = '0;
         rem_in      = '0;
         div_cnt_in  = '0;
         bufoff_in   = '0;
         seg_cnt_in  = '0;
      end

      if (cmd.div_step) begin
         dividend_in = {dividend_ff[OFFSET_W-2:0], 1'b0};
         quo_in      = {quo_ff[INDEX_W-2:0], ~trial[CHUNK_W]};
         rem_in      = trial[CHUNK_W] ? shifted[CHUNK_W-1:0] : trial[CHUNK_W-1:0];
         div_cnt_in  = div_cnt_ff + DIV_CNT_W'(1);
      end

      if (cmd.seg_emit) begin
         out_valid_in = 1'b1;
         out_data_in  = {{(RSP_DATA_W - INDEX_W - IN_CHUNK_W - 2*REQ_BYTES_W){1'b0}},
                         bufoff_ff, take, rem_ff[IN_CHUNK_W-1:0], quo_ff};
         out_last_in  = seg_final;
         quo_in       = quo_ff + INDEX_W'(1);
         rem_in       = '0;
         left_in      = left_after;
         bufoff_in    = bufoff_ff + take;
         seg_cnt_in   = seg_cnt_ff + SEG_CNT_W'(1);
      end
   end

   assign status.div_last  = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.seg_final = seg_final;
   assign status.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign cfg_rdata  = chunk_bytes_ff;

endmodule

FILE: sv/chunk_boundary_request_splitter.sv
// channel  | role            | payload
// req      | stream in       | tdata: start_offset, request_bytes
// rsp      | stream out      | tdata: chunk_index, offset_in_chunk, segment_bytes,
//          |                 |        buffer_offset; tlast: last
// csr      | register port   | chunk_bytes at byte address 0
//
// a request is accepted in idle, runs through the divide state and then emits
// one segment per cycle; the divide uses a one-bit-per-cycle restoring divider
// a stalled rsp word holds the segment loop; req is taken again as soon as the
// final segment sits in the output register
// reset is synchronous and restores chunk_bytes to 4 MiB
module chunk_boundary_request_splitter
   import cbrs_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // start_offset [47:0], request_bytes [73:48]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // chunk_index [31:0], offset_in_chunk [71:32], segment_bytes [97:72],
   // buffer_offset [123:98]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cmd_type            cmd;
   status_type         status;
   logic               cfg_we;
   logic [CHUNK_W-1:0] cfg_rdata;
   logic               reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1] == REG_CHUNK_BYTES);
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   assign csr_prdata = reg_sel ? {{(CSR_DATA_W-CHUNK_W){1'b0}}, cfg_rdata} : '0;

   cbrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cbrs_dp #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cfg_we     (cfg_we),
      .cfg_wdata  (csr_pwdata[CHUNK_W-1:0]),
      .cfg_rdata  (cfg_rdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

FILE: sv/cbrs_checker.sv
`include "assert_macros.svh"

module cbrs_checker
   import cbrs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   `ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `ASSERT_IMPL(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `ASSERT_IMPL(a_idle_only_last, clock, reset, req_tready && rsp_tvalid |-> rsp_tlast)
   `ASSERT_NEVER(a_empty_mid_segment, clock, reset, rsp_tvalid && !rsp_tlast && rsp_tdata[97:72] == '0)

endmodule

bind chunk_boundary_request_splitter cbrs_checker u_cbrs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
